>>> rtl/core/qsf_pkg.sv
// quadratic spline flattener: shared types, widths and state codes
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package qsf_pkg;

    // input coordinates are 16.16, reduced by an arithmetic shift to 6 fraction bits
    localparam int IN_W      = 32;
    localparam int RED_SHIFT = 10;
    localparam int COORD_W   = IN_W - RED_SHIFT;
    // second difference a - 2b + c and the flatness estimate
    localparam int DD_W      = COORD_W + 2;
    localparam int EST_W     = DD_W + 2;

    // flatness register, threshold is 2 << flat_shift
    localparam int FS_W  = 5;
    localparam int THR_W = (1 << FS_W) + 1;
    localparam logic [FS_W-1:0] FLAT_SHIFT_RST = 5'd6;

    // level limits; LVL_W covers the largest allowed clamp of 8
    localparam int MAX_LEAF_LEVEL_DEF  = 5;
    localparam int MAX_LEVEL_CLAMP_DEF = 8;
    localparam int LVL_W = 4;

    // result beat
    localparam int PTS_PER_BEAT = 4;
    localparam int NB_W         = $clog2(PTS_PER_BEAT);
    localparam int CNT_W        = 3;

    typedef struct packed {
        logic signed [IN_W-1:0] start_x;
        logic signed [IN_W-1:0] start_y;
        logic signed [IN_W-1:0] ctrl_x;
        logic signed [IN_W-1:0] ctrl_y;
        logic signed [IN_W-1:0] end_x;
        logic signed [IN_W-1:0] end_y;
    } t_qsf_curve;

    typedef struct packed {
        logic signed [IN_W-1:0] pt0_x;
        logic signed [IN_W-1:0] pt0_y;
        logic signed [IN_W-1:0] pt1_x;
        logic signed [IN_W-1:0] pt1_y;
        logic signed [IN_W-1:0] pt2_x;
        logic signed [IN_W-1:0] pt2_y;
        logic signed [IN_W-1:0] pt3_x;
        logic signed [IN_W-1:0] pt3_y;
        logic [CNT_W-1:0]       point_count;
        logic                   last_beat;
    } t_qsf_beat;

    // reduced curve: start a, control b, end c
    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } t_qsf_quad;

    // flatness unit status
    typedef struct packed {
        logic             done;
        logic [LVL_W-1:0] level;
    } t_qsf_flat;

    // walker control from the sequencer
    typedef struct packed {
        logic             init;
        logic             step;
        logic             last;
        logic [LVL_W-1:0] level;
    } t_qsf_walk_ctl;

    // one vertex handed from walker to beat packer
    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_qsf_pt;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EST,
        ST_LEVEL,
        ST_SPLIT,
        ST_INIT,
        ST_WALK
    } t_qsf_state;

endpackage

>>> rtl/core/qsf_flat_unit.sv
// flatness estimate and iterative level search (one shift-by-two per cycle)
// depends on qsf_pkg
`timescale 1ns / 1ps

module qsf_flat_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  qsf_pkg::t_qsf_quad       i_quad,
    input  logic [qsf_pkg::LVL_W-1:0] i_cap,
    input  logic [qsf_pkg::FS_W-1:0] i_flat_shift,
    output qsf_pkg::t_qsf_flat       o_flat
);
    import qsf_pkg::*;

    logic                      r_run;
    logic [EST_W-1:0]          r_est;
    logic [LVL_W-1:0]          r_level;

    logic signed [DD_W-1:0]    ddx;
    logic signed [DD_W-1:0]    ddy;
    logic [DD_W-1:0]           gx;
    logic [DD_W-1:0]           gy;
    logic [EST_W-1:0]          est;
    logic [FS_W:0]             thr_sh;
    logic [THR_W-1:0]          thr;
    logic                      go_on;

    // second difference and weighted max-norm estimate
    always_comb begin
        ddx = DD_W'(i_quad.ax) - (DD_W'(i_quad.bx) <<< 1) + DD_W'(i_quad.cx);
        ddy = DD_W'(i_quad.ay) - (DD_W'(i_quad.by) <<< 1) + DD_W'(i_quad.cy);
        gx  = ddx[DD_W-1] ? DD_W'(-ddx) : DD_W'(ddx);
        gy  = ddy[DD_W-1] ? DD_W'(-ddy) : DD_W'(ddy);
        if (gx > gy) begin
            est = {1'b0, gx, 1'b0} + EST_W'(gy);
        end else begin
            est = EST_W'(gx) + {1'b0, gy, 1'b0};
        end
    end

    // threshold compare against the shrinking estimate
    always_comb begin
        thr_sh = {1'b0, i_flat_shift} + (FS_W+1)'(1);
        thr    = THR_W'(1) << thr_sh;
        go_on  = (THR_W'(r_est) > thr) && (r_level < i_cap);
    end

    assign o_flat.done  = r_run && !go_on;
    assign o_flat.level = r_level;

    // run flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_load) begin
            r_run <= 1'b1;
        end else if (r_run && !go_on) begin
            r_run <= 1'b0;
        end
    end

    // estimate and level, one quarter step per cycle
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_est   <= est;
            r_level <= LVL_W'(1);
        end else if (r_run && go_on) begin
            r_est   <= r_est >> 2;
            r_level <= r_level + LVL_W'(1);
        end
    end

`ifndef SYNTH
    a_level_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_level <= i_cap))
        else $error("flat unit level above cap");
`endif

endmodule

>>> rtl/core/qsf_walker.sv
// forward-difference walker: one rounded vertex per cycle for a leaf curve
// depends on qsf_pkg
`timescale 1ns / 1ps

module qsf_walker #(
    parameter int MAX_LEAF_LEVEL = qsf_pkg::MAX_LEAF_LEVEL_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  qsf_pkg::t_qsf_quad    i_quad,
    input  qsf_pkg::t_qsf_walk_ctl i_ctl,
    output logic                  o_leaf_end,
    output qsf_pkg::t_qsf_pt      o_pt
);
    import qsf_pkg::*;

    // position scaled by 4^level plus difference headroom
    localparam int ACC_W = COORD_W + 2 * MAX_LEAF_LEVEL + 4;
    localparam int SH_W  = $clog2(2 * MAX_LEAF_LEVEL + 1);
    localparam int LC_W  = MAX_LEAF_LEVEL;
    localparam int NP_W  = LC_W + 1;

    logic signed [ACC_W-1:0] r_px, r_py, r_fdx, r_fdy, r_sdx, r_sdy;
    logic [SH_W-1:0]         r_sh;
    logic [LC_W-1:0]         r_cnt;
    logic                    r_pt_valid;
    logic                    r_pt_last;

    logic [SH_W-1:0]         sh;
    logic [LVL_W-1:0]        step_sh;
    logic [NP_W-1:0]         n_pts;
    logic signed [ACC_W-1:0] ax_e, ay_e, bx_e, by_e, cx_e, cy_e;
    logic signed [ACC_W-1:0] dx_e, dy_e, ddx_e, ddy_e, half;
    logic signed [ACC_W-1:0] px_sh, py_sh;

    // leaf setup values
    always_comb begin
        sh      = SH_W'({i_ctl.level, 1'b0});
        step_sh = i_ctl.level + LVL_W'(1);
        n_pts   = NP_W'(1) << i_ctl.level;
        ax_e    = ACC_W'(i_quad.ax);
        ay_e    = ACC_W'(i_quad.ay);
        bx_e    = ACC_W'(i_quad.bx);
        by_e    = ACC_W'(i_quad.by);
        cx_e    = ACC_W'(i_quad.cx);
        cy_e    = ACC_W'(i_quad.cy);
        dx_e    = ax_e - bx_e;
        dy_e    = ay_e - by_e;
        ddx_e   = dx_e - bx_e + cx_e;
        ddy_e   = dy_e - by_e + cy_e;
        half    = ACC_W'(1) << (sh - SH_W'(1));
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_px  <= (ax_e <<< sh) + half;
            r_py  <= (ay_e <<< sh) + half;
            r_fdx <= ddx_e - (dx_e <<< step_sh);
            r_fdy <= ddy_e - (dy_e <<< step_sh);
            r_sdx <= ddx_e <<< 1;
            r_sdy <= ddy_e <<< 1;
            r_sh  <= sh;
            r_cnt <= LC_W'(n_pts - NP_W'(1));
        end else if (i_ctl.step) begin
            r_px  <= r_px + r_fdx;
            r_py  <= r_py + r_fdy;
            r_fdx <= r_fdx + r_sdx;
            r_fdy <= r_fdy + r_sdy;
            r_cnt <= r_cnt - LC_W'(1);
        end
    end

    // vertex strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt_valid <= 1'b0;
            r_pt_last  <= 1'b0;
        end else begin
            r_pt_valid <= i_ctl.step;
            r_pt_last  <= i_ctl.step && i_ctl.last;
        end
    end

    // rounding shift of the biased position
    always_comb begin
        px_sh = r_px >>> r_sh;
        py_sh = r_py >>> r_sh;
    end

    assign o_leaf_end = (r_cnt == '0);
    assign o_pt.valid = r_pt_valid;
    assign o_pt.last  = r_pt_last;
    assign o_pt.x     = px_sh[COORD_W-1:0];
    assign o_pt.y     = py_sh[COORD_W-1:0];

endmodule

>>> rtl/core/qsf_beat_pack.sv
// gathers vertices four to a beat and drives the registered result strobe
// depends on qsf_pkg
`timescale 1ns / 1ps

module qsf_beat_pack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qsf_pkg::t_qsf_pt   i_pt,
    output logic               o_beat_valid,
    output qsf_pkg::t_qsf_beat o_beat
);
    import qsf_pkg::*;

    logic signed [COORD_W-1:0] r_buf_x [PTS_PER_BEAT-1];
    logic signed [COORD_W-1:0] r_buf_y [PTS_PER_BEAT-1];
    logic [NB_W-1:0]           r_n;
    logic                      r_beat_valid;
    t_qsf_beat                 r_beat;

    logic                      emit;
    logic signed [COORD_W-1:0] slot_x [PTS_PER_BEAT];
    logic signed [COORD_W-1:0] slot_y [PTS_PER_BEAT];
    t_qsf_beat                 n_beat;

    function automatic logic signed [IN_W-1:0] to_fix(input logic signed [COORD_W-1:0] v);
        to_fix = {v, {RED_SHIFT{1'b0}}};
    endfunction

    assign emit = i_pt.valid && ((r_n == NB_W'(PTS_PER_BEAT - 1)) || i_pt.last);

    // beat assembly: buffered vertices, then the new one, unused slots zero
    always_comb begin
        for (int j = 0; j < PTS_PER_BEAT; j++) begin
            slot_x[j] = (NB_W'(j) == r_n) ? i_pt.x : '0;
            slot_y[j] = (NB_W'(j) == r_n) ? i_pt.y : '0;
        end
        for (int j = 0; j < PTS_PER_BEAT - 1; j++) begin
            if (NB_W'(j) < r_n) begin
                slot_x[j] = r_buf_x[j];
                slot_y[j] = r_buf_y[j];
            end
        end
        n_beat.pt0_x       = to_fix(slot_x[0]);
        n_beat.pt0_y       = to_fix(slot_y[0]);
        n_beat.pt1_x       = to_fix(slot_x[1]);
        n_beat.pt1_y       = to_fix(slot_y[1]);
        n_beat.pt2_x       = to_fix(slot_x[2]);
        n_beat.pt2_y       = to_fix(slot_y[2]);
        n_beat.pt3_x       = to_fix(slot_x[3]);
        n_beat.pt3_y       = to_fix(slot_y[3]);
        n_beat.point_count = CNT_W'(r_n) + CNT_W'(1);
        n_beat.last_beat   = i_pt.last;
    end

    // fill count and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n          <= '0;
            r_beat_valid <= 1'b0;
        end else begin
            r_beat_valid <= emit;
            if (emit) begin
                r_n <= '0;
            end else if (i_pt.valid) begin
                r_n <= r_n + NB_W'(1);
            end
        end
    end

    // vertex buffer and result register
    always_ff @(posedge i_clk) begin
        if (i_pt.valid && !emit) begin
            r_buf_x[r_n] <= i_pt.x;
            r_buf_y[r_n] <= i_pt.y;
        end
        if (emit) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat_valid = r_beat_valid;
    assign o_beat       = r_beat;

`ifndef SYNTH
    a_full_unless_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_beat_valid && !r_beat.last_beat) |-> (r_beat.point_count == CNT_W'(PTS_PER_BEAT)))
        else $error("short beat before end of curve");
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat_valid |=> !r_beat_valid)
        else $error("beats on consecutive cycles");
`endif

endmodule

>>> rtl/core/quad_spline_flattener_unit.sv
// quadratic spline flattener top: sequencer, split stack and config register
// depends on qsf_pkg, qsf_flat_unit, qsf_walker, qsf_beat_pack
`timescale 1ns / 1ps

// channel   direction  handshake                     payload
// request   in         start && !busy                i_curve (t_qsf_curve)
// config    in         i_cfg_valid && o_cfg_ready    i_cfg_data (flat_shift)
// beat      out        o_beat_valid, one cycle       o_beat (t_qsf_beat)
//
// a leaf passes the estimate, the level search, the walker setup and the walk, with
// one vertex per cycle from the walker; a split passes the estimate, the level search
// and the split state; the last beat passes the walker's vertex register and the
// packer's result register after the last walk cycle
// reset is synchronous and active low; no storage needs a clearing pass
// beats cannot be held off: o_beat_valid marks each for exactly one cycle
module quad_spline_flattener_unit #(
    parameter int MAX_LEAF_LEVEL  = qsf_pkg::MAX_LEAF_LEVEL_DEF,
    parameter int MAX_LEVEL_CLAMP = qsf_pkg::MAX_LEVEL_CLAMP_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  qsf_pkg::t_qsf_curve       i_curve,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [qsf_pkg::FS_W-1:0]  i_cfg_data,
    output logic                      o_beat_valid,
    output qsf_pkg::t_qsf_beat        o_beat
);
    import qsf_pkg::*;

    // pending second halves, one per split level
    localparam int STK_D  = MAX_LEVEL_CLAMP - MAX_LEAF_LEVEL + 1;
    localparam int STK_AW = (STK_D > 1) ? $clog2(STK_D) : 1;

    t_qsf_state        r_state, n_state;
    logic [FS_W-1:0]   r_flat_shift;
    t_qsf_quad         r_curve;
    logic [LVL_W-1:0]  r_cap;
    logic [STK_AW-1:0] r_sp;
    t_qsf_quad         r_stk_curve [STK_D];
    logic [LVL_W-1:0]  r_stk_cap   [STK_D];

    logic              flat_load;
    t_qsf_flat         flat;
    t_qsf_walk_ctl     walk_ctl;
    logic              leaf_end;
    t_qsf_pt           pt;
    logic [STK_AW-1:0] sp_top;
    logic              stk_empty;
    logic [LVL_W-1:0]  sub_cap;
    t_qsf_quad         half_a, half_b;

    function automatic logic signed [COORD_W-1:0] avg2(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] s;
        s    = (COORD_W+1)'(a) + (COORD_W+1)'(b) + (COORD_W+1)'(1);
        avg2 = s[COORD_W:1];
    endfunction

    function automatic logic signed [COORD_W-1:0] mid3(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [COORD_W+2:0] s;
        s    = (COORD_W+3)'(a) + ((COORD_W+3)'(b) <<< 1) + (COORD_W+3)'(c)
             + (COORD_W+3)'(2);
        mid3 = s[COORD_W+1:2];
    endfunction

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = !busy;
    assign sp_top      = r_sp - STK_AW'(1);
    assign stk_empty   = (r_sp == '0);
    assign sub_cap     = flat.level - LVL_W'(1);

    // midpoint split of the current curve
    always_comb begin
        half_a.ax = r_curve.ax;
        half_a.ay = r_curve.ay;
        half_a.bx = avg2(r_curve.ax, r_curve.bx);
        half_a.by = avg2(r_curve.ay, r_curve.by);
        half_a.cx = mid3(r_curve.ax, r_curve.bx, r_curve.cx);
        half_a.cy = mid3(r_curve.ay, r_curve.by, r_curve.cy);
        half_b.ax = half_a.cx;
        half_b.ay = half_a.cy;
        half_b.bx = avg2(r_curve.cx, r_curve.bx);
        half_b.by = avg2(r_curve.cy, r_curve.by);
        half_b.cx = r_curve.cx;
        half_b.cy = r_curve.cy;
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state and unit controls
    always_comb begin
        n_state        = r_state;
        flat_load      = 1'b0;
        walk_ctl.init  = 1'b0;
        walk_ctl.step  = 1'b0;
        walk_ctl.last  = 1'b0;
        walk_ctl.level = flat.level;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EST;
                end
            end
            ST_EST: begin
                flat_load = 1'b1;
                n_state   = ST_LEVEL;
            end
            ST_LEVEL: begin
                if (flat.done) begin
                    n_state = (flat.level > LVL_W'(MAX_LEAF_LEVEL)) ? ST_SPLIT : ST_INIT;
                end
            end
            ST_SPLIT: begin
                n_state = ST_EST;
            end
            ST_INIT: begin
                walk_ctl.init = 1'b1;
                n_state       = ST_WALK;
            end
            ST_WALK: begin
                walk_ctl.step = 1'b1;
                walk_ctl.last = leaf_end && stk_empty;
                if (leaf_end) begin
                    n_state = stk_empty ? ST_IDLE : ST_EST;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // flatness register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flat_shift <= FLAT_SHIFT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_flat_shift <= i_cfg_data;
        end
    end

    // stack pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (r_state == ST_IDLE && start) begin
            r_sp <= '0;
        end else if (r_state == ST_SPLIT) begin
            r_sp <= r_sp + STK_AW'(1);
        end else if (r_state == ST_WALK && leaf_end && !stk_empty) begin
            r_sp <= sp_top;
        end
    end

    // current curve, its level cap and the split stack
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_curve.ax <= i_curve.start_x[IN_W-1:RED_SHIFT];
            r_curve.ay <= i_curve.start_y[IN_W-1:RED_SHIFT];
            r_curve.bx <= i_curve.ctrl_x[IN_W-1:RED_SHIFT];
            r_curve.by <= i_curve.ctrl_y[IN_W-1:RED_SHIFT];
            r_curve.cx <= i_curve.end_x[IN_W-1:RED_SHIFT];
            r_curve.cy <= i_curve.end_y[IN_W-1:RED_SHIFT];
            r_cap      <= LVL_W'(MAX_LEVEL_CLAMP);
        end else if (r_state == ST_SPLIT) begin
            r_stk_curve[r_sp] <= half_b;
            r_stk_cap[r_sp]   <= sub_cap;
            r_curve           <= half_a;
            r_cap             <= sub_cap;
        end else if (r_state == ST_WALK && leaf_end && !stk_empty) begin
            r_curve <= r_stk_curve[sp_top];
            r_cap   <= r_stk_cap[sp_top];
        end
    end

    qsf_flat_unit u_flat (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (flat_load),
        .i_quad       (r_curve),
        .i_cap        (r_cap),
        .i_flat_shift (r_flat_shift),
        .o_flat       (flat)
    );

    qsf_walker #(
        .MAX_LEAF_LEVEL (MAX_LEAF_LEVEL)
    ) u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_quad     (r_curve),
        .i_ctl      (walk_ctl),
        .o_leaf_end (leaf_end),
        .o_pt       (pt)
    );

    qsf_beat_pack u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pt         (pt),
        .o_beat_valid (o_beat_valid),
        .o_beat       (o_beat)
    );

`ifndef SYNTH
    a_split_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SPLIT) |-> (r_sp < STK_AW'(STK_D - 1)))
        else $error("split with no room on stack");
`endif

endmodule

>>> bench/tb_top.sv
// testbench for quad_spline_flattener_unit: drives curve requests and flat_shift writes
// checks every polyline beat against an in-bench forward-difference predictor; needs qsf_pkg
`timescale 1ns / 1ps

module tb_top;
    import qsf_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int LEVEL_CAP   = MAX_LEVEL_CLAMP_DEF;
    localparam int LEAF_LIMIT  = MAX_LEAF_LEVEL_DEF;
    localparam int PER_SETTING = 70;

    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;

    // one pending piece of curve in reduced coordinates, with its level ceiling
    typedef struct packed {
        logic signed [63:0] ax, ay, bx, by, cx, cy;
        logic [3:0]         cap;
    } t_quad_job;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_qsf_curve       curve_req;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [FS_W-1:0]  cfg_data;
    logic             beat_valid;
    t_qsf_beat        beat_out;

    logic [FS_W-1:0]  shift_model;
    t_qsf_beat        pending_beats[$];
    t_qsf_beat        want_beat;
    longint           vert_x[$];
    longint           vert_y[$];
    int               send_idle_pct = 0;
    int               mismatch_count = 0;

    quad_spline_flattener_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_curve      (curve_req),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_beat_valid (beat_valid),
        .o_beat       (beat_out)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // predictor: subdivide depth first, walk each leaf, pack vertices four per beat
    function automatic void predict_beats(input t_qsf_curve c);
        t_quad_job          work[$];
        t_quad_job          job;
        t_quad_job          half1;
        t_quad_job          half2;
        t_qsf_beat          b;
        logic signed [31:0] slot_x[4];
        logic signed [31:0] slot_y[4];
        longint             ax, ay, bx, by, cx, cy;
        longint             dx, dy, ddx, ddy, gx, gy, est, thr, mx, my;
        longint             fdx, fdy, sdx, sdy, px, py, rnd;
        int                 lvl, sh, nv, nbeats, cnt, bi, j, k;

        vert_x.delete();
        vert_y.delete();
        job.ax  = longint'(c.start_x) >>> RED_SHIFT;
        job.ay  = longint'(c.start_y) >>> RED_SHIFT;
        job.bx  = longint'(c.ctrl_x) >>> RED_SHIFT;
        job.by  = longint'(c.ctrl_y) >>> RED_SHIFT;
        job.cx  = longint'(c.end_x) >>> RED_SHIFT;
        job.cy  = longint'(c.end_y) >>> RED_SHIFT;
        job.cap = 4'(LEVEL_CAP);
        work.push_back(job);

        while (work.size() > 0) begin
            job = work.pop_back();
            ax = job.ax; ay = job.ay;
            bx = job.bx; by = job.by;
            cx = job.cx; cy = job.cy;
            dx  = ax - bx;
            dy  = ay - by;
            ddx = dx - bx + cx;
            ddy = dy - by + cy;
            gx  = (ddx < 0) ? -ddx : ddx;
            gy  = (ddy < 0) ? -ddy : ddy;
            est = (gx > gy) ? 2 * gx + gy : gx + 2 * gy;
            thr = longint'(1) << (int'(shift_model) + 1);

            // level search: one step per factor of four above the threshold
            lvl = 1;
            while (est > thr && lvl < int'(job.cap)) begin
                est = est >>> 2;
                lvl++;
            end

            if (lvl > LEAF_LIMIT) begin
                // midpoint split, first half goes on top of the stack
                mx = (ax + 2 * bx + cx + 2) >>> 2;
                my = (ay + 2 * by + cy + 2) >>> 2;
                half1.ax = ax;
                half1.ay = ay;
                half1.bx = (ax + bx + 1) >>> 1;
                half1.by = (ay + by + 1) >>> 1;
                half1.cx = mx;
                half1.cy = my;
                half1.cap = 4'(lvl - 1);
                half2.ax = mx;
                half2.ay = my;
                half2.bx = (cx + bx + 1) >>> 1;
                half2.by = (cy + by + 1) >>> 1;
                half2.cx = cx;
                half2.cy = cy;
                half2.cap = 4'(lvl - 1);
                work.push_back(half2);
                work.push_back(half1);
            end else begin
                // forward differencing, start point skipped, rounded to nearest
                sh  = 2 * lvl;
                rnd = longint'(1) << (sh - 1);
                fdx = ddx - dx * (longint'(1) << (lvl + 1));
                fdy = ddy - dy * (longint'(1) << (lvl + 1));
                sdx = 2 * ddx;
                sdy = 2 * ddy;
                px  = ax * (longint'(1) << sh);
                py  = ay * (longint'(1) << sh);
                nv  = 1 << lvl;
                for (k = 0; k < nv; k++) begin
                    px  = px + fdx;
                    fdx = fdx + sdx;
                    py  = py + fdy;
                    fdy = fdy + sdy;
                    vert_x.push_back((px + rnd) >>> sh);
                    vert_y.push_back((py + rnd) >>> sh);
                end
            end
        end

        // pack into beats, unused slots zero
        nv = vert_x.size();
        nbeats = (nv + 3) / 4;
        for (bi = 0; bi < nbeats; bi++) begin
            cnt = nv - bi * 4;
            if (cnt > 4) begin
                cnt = 4;
            end
            for (j = 0; j < 4; j++) begin
                slot_x[j] = '0;
                slot_y[j] = '0;
                if (j < cnt) begin
                    slot_x[j] = 32'(vert_x[bi * 4 + j] <<< RED_SHIFT);
                    slot_y[j] = 32'(vert_y[bi * 4 + j] <<< RED_SHIFT);
                end
            end
            b.pt0_x = slot_x[0];
            b.pt0_y = slot_y[0];
            b.pt1_x = slot_x[1];
            b.pt1_y = slot_y[1];
            b.pt2_x = slot_x[2];
            b.pt2_y = slot_y[2];
            b.pt3_x = slot_x[3];
            b.pt3_y = slot_y[3];
            b.point_count = CNT_W'(cnt);
            b.last_beat = (bi == nbeats - 1);
            pending_beats.push_back(b);
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] expv,
                                        input logic [31:0] actv);
        if (expv !== actv) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actv);
            mismatch_count++;
        end
    endfunction

    // beat checker: every strobed beat must match the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && beat_valid) begin
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, beat_out);
                mismatch_count++;
            end else begin
                want_beat = pending_beats.pop_front();
                check_field("pt0_x", want_beat.pt0_x, beat_out.pt0_x);
                check_field("pt0_y", want_beat.pt0_y, beat_out.pt0_y);
                check_field("pt1_x", want_beat.pt1_x, beat_out.pt1_x);
                check_field("pt1_y", want_beat.pt1_y, beat_out.pt1_y);
                check_field("pt2_x", want_beat.pt2_x, beat_out.pt2_x);
                check_field("pt2_y", want_beat.pt2_y, beat_out.pt2_y);
                check_field("pt3_x", want_beat.pt3_x, beat_out.pt3_x);
                check_field("pt3_y", want_beat.pt3_y, beat_out.pt3_y);
                check_field("point_count", 32'(want_beat.point_count),
                            32'(beat_out.point_count));
                check_field("last_beat", 32'(want_beat.last_beat), 32'(beat_out.last_beat));
            end
        end
    end

    function automatic t_qsf_curve make_curve(
        input logic signed [31:0] sx, input logic signed [31:0] sy,
        input logic signed [31:0] qx, input logic signed [31:0] qy,
        input logic signed [31:0] ex, input logic signed [31:0] ey);
        t_qsf_curve c;
        c.start_x = sx;
        c.start_y = sy;
        c.ctrl_x  = qx;
        c.ctrl_y  = qy;
        c.end_x   = ex;
        c.end_y   = ey;
        return c;
    endfunction

    function automatic logic signed [31:0] corner_value();
        case ($urandom_range(0, 4))
            0: return C_MIN;
            1: return C_MAX;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // signed offset of roughly +/- 2^bits
    function automatic logic signed [31:0] wobble(input int bits);
        return $signed($urandom) >>> (31 - bits);
    endfunction

    // mostly local curves with random size and bend, some noise and corner values
    function automatic t_qsf_curve random_curve();
        t_qsf_curve         c;
        logic signed [31:0] ox, oy;
        int                 pick, span, bend;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else if (pick < 25) begin
            c = make_curve(corner_value(), corner_value(), corner_value(),
                           corner_value(), corner_value(), corner_value());
        end else begin
            ox   = $urandom;
            oy   = $urandom;
            span = $urandom_range(0, 30);
            bend = $urandom_range(0, 30);
            c = make_curve(ox + wobble(span), oy + wobble(span),
                           ox + wobble(bend), oy + wobble(bend),
                           ox + wobble(span), oy + wobble(span));
        end
        return c;
    endfunction

    // send one curve request, with random idle cycles ahead of it
    task automatic send_curve(input t_qsf_curve c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        curve_req <= c;
        do @(posedge i_clk); while (busy);
        predict_beats(c);
    endtask

    // stop requesting and wait for all beats and for the unit to go idle
    task automatic drain_beats();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_beats.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_flat_shift(input logic [FS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        shift_model = value;
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // reset flat_shift: bends on x, y and both, from straight up to the clamp
    task automatic test_level_ramp();
        send_curve(make_curve(0, 0, 0, 0, 0, 0));
        // estimate equal to the threshold stays at level one, one more steps up
        send_curve(make_curve(0, 0, 32 <<< 10, 0, 0, 0));
        send_curve(make_curve(0, 0, 33 <<< 10, 0, 0, 0));
        send_curve(make_curve(0, 0, 8000 <<< 10, 0, 0, 0));
        send_curve(make_curve(0, 0, 30000 <<< 10, 0, 0, 0));
        send_curve(make_curve(0, 0, 0, -30000 <<< 10, 0, 0));
        send_curve(make_curve(0, 0, 1 <<< 30, 0, 0, 0));
        // equal axis magnitudes
        send_curve(make_curve(0, 0, 8000 <<< 10, 8000 <<< 10, 0, 0));
        drain_beats();
    endtask

    // coordinate extremes, negative rounding and a straight line
    task automatic test_corner_points();
        send_curve(make_curve(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
        send_curve(make_curve(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
        send_curve(make_curve(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN));
        send_curve(make_curve(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN));
        send_curve(make_curve(-1, -1, -1, -1, -1, -1));
        send_curve(make_curve(-(5 <<< 16), 3 <<< 16, 1 <<< 16, 1 <<< 16,
                              7 <<< 16, -(1 <<< 16)));
        send_curve(make_curve(1023, -1025, 3 <<< 10, -(7 <<< 10), 1 <<< 10, 5 <<< 10));
        drain_beats();
    endtask

    // smallest and largest threshold settings, then a setting of 20
    task automatic test_shift_extremes();
        write_flat_shift(5'd0);
        send_curve(make_curve(0, 0, 1 <<< 10, 0, 0, 0));
        send_curve(make_curve(0, 0, 1 <<< 10, 1 <<< 10, 0, 0));
        send_curve(make_curve(0, 0, 33 <<< 10, 0, 0, 0));
        drain_beats();
        write_flat_shift(5'd31);
        send_curve(make_curve(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN));
        send_curve(make_curve(C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX));
        drain_beats();
        write_flat_shift(5'd20);
        send_curve(make_curve(C_MIN, 0, C_MAX, 0, C_MIN, 0));
        drain_beats();
    endtask

    // random curves in three idle regimes, two thresholds each
    task automatic test_random_traffic();
        int phase, setting;
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 47 : 0;
            for (setting = 0; setting < 2; setting++) begin
                if ($urandom_range(0, 3) == 0) begin
                    write_flat_shift(FS_W'($urandom_range(13, 31)));
                end else begin
                    write_flat_shift(FS_W'($urandom_range(0, 12)));
                end
                repeat (PER_SETTING) send_curve(random_curve());
                drain_beats();
            end
        end
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        curve_req <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        shift_model = FLAT_SHIFT_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_level_ramp();
        test_corner_points();
        test_shift_extremes();
        test_random_traffic();

        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_beats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // timeout
    initial begin
        #(10_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/core/qsf_pkg.sv
rtl/core/qsf_flat_unit.sv
rtl/core/qsf_walker.sv
rtl/core/qsf_beat_pack.sv
rtl/core/quad_spline_flattener_unit.sv
bench/tb_top.sv
